// ===== rtl/upd_pkg.sv =====
// Shared types, constants and helper functions of the URL percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

    localparam logic [7:0] CHAR_QUERY   = 8'h3F; // '?'
    localparam logic [7:0] CHAR_PLUS    = 8'h2B; // '+'
    localparam logic [7:0] CHAR_PERCENT = 8'h25; // '%'
    localparam logic [7:0] CHAR_AT      = 8'h40; // '@'
    localparam logic [7:0] CHAR_SPACE   = 8'h20; // ' '
    localparam logic [7:0] CHAR_ZERO    = 8'h30; // '0'
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0] ALPHA_ADJUST = 8'h09;

    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_PERCENT,
        ESC_DIGIT
    } upd_esc_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       in_query;
        logic       end_of_string;
    } upd_out_t;

    // Up to three results produced by one input byte, slot 0 delivered first.
    typedef struct packed {
        logic [1:0]                    count;
        upd_out_t [MAX_RESULTS-1:0]    slot;
    } upd_batch_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c < CHAR_AT) begin
            v = (c - CHAR_ZERO) & NIBBLE_MASK;
        end else begin
            v = ((c & NIBBLE_MASK) + ALPHA_ADJUST) & NIBBLE_MASK;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/upd_decode.sv =====
// Escape state and single-pass decode of one byte into a batch of results.
`timescale 1ns / 1ps

module upd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               consume,
    input  upd_pkg::upd_in_t   item,
    input  logic               split_mode,
    output upd_pkg::upd_batch_t batch
);

    upd_pkg::upd_esc_t phase_reg, phase_next;
    logic [7:0]        held_reg, held_next;
    logic              query_reg, query_next;

    // Shared intermediate values of one step.
    logic              hex;
    logic              plain_active;
    logic              plain_emit;
    logic [7:0]        plain_val;
    logic              plain_sets_query;
    logic              plain_sets_pct;
    upd_pkg::upd_esc_t phase_after;
    logic [7:0]        held_after;
    logic              query_after;

    always_comb
    begin
        hex              = upd_pkg::is_hex(item.in_byte);
        plain_active     = !(((phase_reg == upd_pkg::ESC_PERCENT) ||
                              (phase_reg == upd_pkg::ESC_DIGIT)) && hex);
        plain_emit       = 1'b0;
        plain_val        = item.in_byte;
        plain_sets_query = 1'b0;
        plain_sets_pct   = 1'b0;
        if (split_mode && !query_reg && (item.in_byte == upd_pkg::CHAR_QUERY)) begin
            plain_sets_query = 1'b1;
        end else if ((item.in_byte == upd_pkg::CHAR_PLUS) && (query_reg || !split_mode)) begin
            plain_emit = 1'b1;
            plain_val  = upd_pkg::CHAR_SPACE;
        end else if (item.in_byte == upd_pkg::CHAR_PERCENT) begin
            plain_sets_pct = 1'b1;
        end else begin
            plain_emit = 1'b1;
        end

        if ((phase_reg == upd_pkg::ESC_PERCENT) && hex) begin
            phase_after = upd_pkg::ESC_DIGIT;
            held_after  = item.in_byte;
        end else begin
            phase_after = (plain_active && plain_sets_pct) ? upd_pkg::ESC_PERCENT
                                                           : upd_pkg::ESC_IDLE;
            held_after  = held_reg;
        end
        query_after = query_reg | (plain_active & plain_sets_query);
    end

    // Result batch.
    always_comb
    begin
        logic [1:0] n;
        logic       q0;
        upd_pkg::upd_out_t [upd_pkg::MAX_RESULTS-1:0] slot;
        n    = 2'd0;
        q0   = query_reg & split_mode;
        slot = '0;

        if ((phase_reg == upd_pkg::ESC_DIGIT) && hex) begin
            slot[n] = '{out_byte: {upd_pkg::hex_value(held_reg),
                                   upd_pkg::hex_value(item.in_byte)},
                        has_byte: 1'b1, in_query: q0, end_of_string: 1'b0};
            n = n + 2'd1;
        end else if (((phase_reg == upd_pkg::ESC_PERCENT) ||
                      (phase_reg == upd_pkg::ESC_DIGIT)) && !hex) begin
            // A broken escape goes out literally before the byte itself.
            slot[n] = '{out_byte: upd_pkg::CHAR_PERCENT, has_byte: 1'b1,
                        in_query: q0, end_of_string: 1'b0};
            n = n + 2'd1;
            if (phase_reg == upd_pkg::ESC_DIGIT) begin
                slot[n] = '{out_byte: held_reg, has_byte: 1'b1,
                            in_query: q0, end_of_string: 1'b0};
                n = n + 2'd1;
            end
        end

        if (plain_active && plain_emit) begin
            slot[n] = '{out_byte: plain_val, has_byte: 1'b1,
                        in_query: q0, end_of_string: 1'b0};
            n = n + 2'd1;
        end

        if (item.last_byte) begin
            if ((phase_after == upd_pkg::ESC_PERCENT) ||
                (phase_after == upd_pkg::ESC_DIGIT)) begin
                slot[n] = '{out_byte: upd_pkg::CHAR_PERCENT, has_byte: 1'b1,
                            in_query: q0, end_of_string: 1'b0};
                n = n + 2'd1;
            end
            if (phase_after == upd_pkg::ESC_DIGIT) begin
                slot[n] = '{out_byte: held_after, has_byte: 1'b1,
                            in_query: q0, end_of_string: 1'b0};
                n = n + 2'd1;
            end
            if (n == 2'd0) begin
                // Nothing came out of the final byte: send a bare end marker.
                slot[n] = '{out_byte: 8'h00, has_byte: 1'b0,
                            in_query: query_after & split_mode, end_of_string: 1'b0};
                n = n + 2'd1;
            end
            slot[n - 2'd1].end_of_string = 1'b1;
        end

        batch.count = n;
        batch.slot  = slot;
    end

    // Next state.
    always_comb
    begin
        if (item.last_byte) begin
            phase_next = upd_pkg::ESC_IDLE;
            held_next  = 8'h00;
            query_next = 1'b0;
        end else begin
            phase_next = phase_after;
            held_next  = held_after;
            query_next = query_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= upd_pkg::ESC_IDLE;
            held_reg  <= 8'h00;
            query_reg <= 1'b0;
        end else if (consume) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            query_reg <= query_next;
        end
    end

endmodule

// ===== rtl/upd_result_queue.sv =====
// Three-slot result register that delivers a batch one transfer at a time.
`timescale 1ns / 1ps

module upd_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  upd_pkg::upd_batch_t batch,
    output logic                can_load,
    output logic                result_valid,
    input  logic                result_stall,
    output upd_pkg::upd_out_t   result
);

    logic [1:0]        count_reg;
    upd_pkg::upd_out_t slot0_reg, slot1_reg, slot2_reg;
    logic              fire;

    assign result_valid = (count_reg != 2'd0);
    assign result       = slot0_reg;
    assign fire         = result_valid && !result_stall;
    // A new batch may enter when empty or as the last result leaves.
    assign can_load     = (count_reg == 2'd0) || ((count_reg == 2'd1) && fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
        end else if (load) begin
            count_reg <= batch.count;
        end else if (fire) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            slot0_reg <= batch.slot[0];
            slot1_reg <= batch.slot[1];
            slot2_reg <= batch.slot[2];
        end else if (fire) begin
            slot0_reg <= slot1_reg;
            slot1_reg <= slot2_reg;
        end
    end

endmodule

// ===== rtl/url_percent_decoder_query_split_unit.sv =====
// Top level of the streaming URL percent decoder with path/query split.
//
//   channel  direction  payload              handshake
//   item     in         upd_in_t             item_valid / item_stall
//   result   out        upd_out_t            result_valid / result_stall
//   cfg      in         split_query_mode     cfg_wen / cfg_wdata
//
// One byte is taken per cycle when the result register can take its batch; its results
// pass through the input register and then the result register. A byte yielding two or
// three results holds the input; results drain one transfer per cycle when not stalled.
// Reset clears the escape state, the query flag and both valid registers,
// and sets split mode. A stalled result stalls the input register behind it.
`timescale 1ns / 1ps

module url_percent_decoder_query_split_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  upd_pkg::upd_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output upd_pkg::upd_out_t result,
    input  logic              cfg_wen,
    input  logic              cfg_wdata
);

    logic                in_vld_reg, in_vld_next;
    upd_pkg::upd_in_t    in_item_reg;
    logic                split_mode_reg;
    logic                consume;
    logic                can_load;
    upd_pkg::upd_batch_t batch;

    assign consume    = in_vld_reg && can_load;
    assign item_stall = in_vld_reg && !can_load;

    always_comb
    begin
        if (item_valid && !item_stall)
        begin
            in_vld_next = 1'b1;
        end
        else if (consume)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            split_mode_reg <= 1'b1;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_wen)
            begin
                split_mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    upd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .consume    (consume),
        .item       (in_item_reg),
        .split_mode (split_mode_reg),
        .batch      (batch)
    );

    upd_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (consume),
        .batch        (batch),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/upd_decode_checker.sv =====
// Checker that predicts the decoded result stream and compares each result transfer with it.
`timescale 1ns / 1ps

module upd_decode_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  upd_pkg::upd_in_t  item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  upd_pkg::upd_out_t result,
    input  logic              cfg_wen,
    input  logic              cfg_wdata,
    output int                fail_count,
    output int                expected_left
);

    upd_pkg::upd_out_t decoded_due[$];
    upd_pkg::upd_out_t step_out[$];
    upd_pkg::upd_esc_t esc_phase;
    logic [7:0]        first_digit;
    logic              query_seen;
    logic              split_mode;

    function automatic logic is_hex_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c & 8'hDF;
        return ((c >= 8'h30) && (c <= 8'h39)) || ((folded >= 8'h41) && (folded <= 8'h46));
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= 8'h39)
        begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic add_result(input logic [7:0] b, input logic has);
        upd_pkg::upd_out_t r;
        r.out_byte      = has ? b : 8'h00;
        r.has_byte      = has;
        r.in_query      = query_seen & split_mode;
        r.end_of_string = 1'b0;
        if (step_out.size() < upd_pkg::MAX_RESULTS)
        begin
            step_out.push_back(r);
        end
    endtask

    // Byte handling with no escape pending.
    task automatic decode_plain(input logic [7:0] b);
        if (split_mode && !query_seen && b == upd_pkg::CHAR_QUERY)
        begin
            query_seen = 1'b1;
        end
        else if (b == upd_pkg::CHAR_PLUS && (query_seen || !split_mode))
        begin
            add_result(upd_pkg::CHAR_SPACE, 1'b1);
        end
        else if (b == upd_pkg::CHAR_PERCENT)
        begin
            esc_phase = upd_pkg::ESC_PERCENT;
        end
        else
        begin
            add_result(b, 1'b1);
        end
    endtask

    task automatic predict_item(input upd_pkg::upd_in_t it);
        step_out.delete();
        case (esc_phase)
            upd_pkg::ESC_PERCENT:
            begin
                if (is_hex_char(it.in_byte))
                begin
                    first_digit = it.in_byte;
                    esc_phase   = upd_pkg::ESC_DIGIT;
                end
                else
                begin
                    add_result(upd_pkg::CHAR_PERCENT, 1'b1);
                    esc_phase = upd_pkg::ESC_IDLE;
                    decode_plain(it.in_byte);
                end
            end
            upd_pkg::ESC_DIGIT:
            begin
                if (is_hex_char(it.in_byte))
                begin
                    add_result({nibble_of(first_digit), nibble_of(it.in_byte)}, 1'b1);
                    esc_phase = upd_pkg::ESC_IDLE;
                end
                else
                begin
                    add_result(upd_pkg::CHAR_PERCENT, 1'b1);
                    add_result(first_digit, 1'b1);
                    esc_phase = upd_pkg::ESC_IDLE;
                    decode_plain(it.in_byte);
                end
            end
            default:
            begin
                esc_phase = upd_pkg::ESC_IDLE;
                decode_plain(it.in_byte);
            end
        endcase

        if (it.last_byte)
        begin
            // A pending escape is flushed literally at the end of the string.
            if (esc_phase == upd_pkg::ESC_PERCENT)
            begin
                add_result(upd_pkg::CHAR_PERCENT, 1'b1);
            end
            else if (esc_phase == upd_pkg::ESC_DIGIT)
            begin
                add_result(upd_pkg::CHAR_PERCENT, 1'b1);
                add_result(first_digit, 1'b1);
            end
            if (step_out.size() == 0)
            begin
                add_result(8'h00, 1'b0);
            end
            step_out[step_out.size() - 1].end_of_string = 1'b1;
            esc_phase   = upd_pkg::ESC_IDLE;
            first_digit = 8'h00;
            query_seen  = 1'b0;
        end

        foreach (step_out[i])
        begin
            decoded_due.push_back(step_out[i]);
        end
    endtask

    task automatic check_result();
        upd_pkg::upd_out_t want;
        if (decoded_due.size() == 0)
        begin
            report_mismatch($sformatf(
                "result with nothing expected: byte %02h has %0b query %0b end %0b",
                result.out_byte, result.has_byte, result.in_query, result.end_of_string));
        end
        else
        begin
            want = decoded_due.pop_front();
            if (result.out_byte !== want.out_byte || result.has_byte !== want.has_byte ||
                result.in_query !== want.in_query ||
                result.end_of_string !== want.end_of_string)
            begin
                report_mismatch($sformatf({"got byte %02h has %0b query %0b end %0b, ",
                    "want byte %02h has %0b query %0b end %0b"},
                    result.out_byte, result.has_byte, result.in_query, result.end_of_string,
                    want.out_byte, want.has_byte, want.in_query, want.end_of_string));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_due.delete();
            fail_count    = 0;
            esc_phase     = upd_pkg::ESC_IDLE;
            first_digit   = 8'h00;
            query_seen    = 1'b0;
            split_mode    = 1'b1;
            expected_left <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_result();
            end
            if (item_valid && !item_stall)
            begin
                predict_item(item);
            end
            if (cfg_wen)
            begin
                split_mode = cfg_wdata;
            end
            expected_left <= decoded_due.size();
        end
    end

endmodule

// ===== verif/url_percent_decoder_query_split_unit_tb.sv =====
// Testbench top for the URL percent decoder: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module url_percent_decoder_query_split_unit_tb;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    upd_pkg::upd_in_t  item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    upd_pkg::upd_out_t result;
    logic              cfg_wen      = 1'b0;
    logic              cfg_wdata    = 1'b1;

    int         fail_count;
    int         expected_left;

    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;
    int         hold_req      = 0;
    int         hold_ack;
    int         hold_left;

    int         bytes_sent   = 0;
    int         strings_sent = 0;
    int         mode_writes  = 0;
    logic [7:0] text[$];

    url_percent_decoder_query_split_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata)
    );

    upd_decode_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_ack  = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = 50;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    task automatic offer_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        item.in_byte   <= b;
        item.last_byte <= last;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (last)
        begin
            strings_sent++;
        end
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            offer_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Stop offering and wait until every predicted result has been transferred.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        mode_writes++;
    endtask

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(21);
        if (r < 10)
        begin
            return 8'h30 + 8'(r);
        end
        else if (r < 16)
        begin
            return 8'h61 + 8'(r - 10);
        end
        return 8'h41 + 8'(r - 16);
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(3))
            0:       return 8'h67 + 8'($urandom_range(19));
            1:       return upd_pkg::CHAR_QUERY;
            2:       return upd_pkg::CHAR_PLUS;
            default: return upd_pkg::CHAR_PERCENT;
        endcase
    endfunction

    // Builds a short string of tokens: plain text, valid and broken escapes, '+', '?'.
    task automatic make_string();
        int tokens;
        text.delete();
        tokens = $urandom_range(1, 6);
        repeat (tokens)
        begin
            case ($urandom_range(9))
                0, 1, 2: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                3:       text.push_back(8'($urandom_range(255)));
                4, 5:
                begin
                    text.push_back(upd_pkg::CHAR_PERCENT);
                    text.push_back(hex_char());
                    text.push_back(hex_char());
                end
                6:       text.push_back(upd_pkg::CHAR_PLUS);
                7:       text.push_back(upd_pkg::CHAR_QUERY);
                8:
                begin
                    text.push_back(upd_pkg::CHAR_PERCENT);
                    if ($urandom_range(1))
                    begin
                        text.push_back(hex_char());
                    end
                    text.push_back(non_hex_char());
                end
                default: text.push_back(upd_pkg::CHAR_PERCENT);
            endcase
        end
    endtask

    task automatic send_text();
        foreach (text[i])
        begin
            offer_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input int budget);
        int start;
        int strings;
        start   = bytes_sent;
        strings = 0;
        sink_idle_pct = sink_pct;

        // Long receiver hold-off while the sender keeps offering, so the block backs up.
        src_idle_pct = 0;
        hold_req <= hold_req + 1;
        while (bytes_sent - start < 30)
        begin
            make_string();
            send_text();
        end

        src_idle_pct = src_pct;
        while (bytes_sent - start < budget)
        begin
            make_string();
            send_text();
            strings++;
            if (strings % 10 == 0)
            begin
                write_mode(1'($urandom_range(1)));
            end
        end
        settle();
    endtask

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 23;
        sink_idle_pct = 52;

        // Split mode out of reset.
        send_str("%4a");
        send_str("+?+?");
        send_str("%Z%4?");
        send_str("%F%");
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b1);
        send_str("?");
        send_str("%");

        write_mode(1'b0);
        send_str("?+%2B");

        // Mode switched while a string is in progress.
        write_mode(1'b1);
        offer_byte(upd_pkg::CHAR_QUERY, 1'b0);
        write_mode(1'b0);
        offer_byte(upd_pkg::CHAR_PLUS, 1'b0);
        write_mode(1'b1);
        offer_byte(8'h78, 1'b1);
        settle();

        run_phase(23, 52, 135);
        run_phase(52, 23, 135);
        run_phase(0, 0, 135);

        $display("Covered %0d bytes in %0d strings with %0d mode writes across both modes,",
            bytes_sent, strings_sent, mode_writes);
        $display("three flow-control profiles and a long result hold-off in each.");
        if (fail_count == 0)
        begin
            $display("url_percent_decoder_query_split_unit_tb passed");
        end
        else
        begin
            $display("url_percent_decoder_query_split_unit_tb failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Timeout with %0d results still expected.", expected_left);
        $display("url_percent_decoder_query_split_unit_tb failed");
        $finish;
    end

endmodule
